>>> hw/rtl/ptar_pkg.sv
// Shared types and constants for the planar tile row decoder.
// Holds the fixed colour ROM and the palette write request.
// No dependencies.
package ptar_pkg;

	localparam int unsigned PalRows  = 8;
	localparam int unsigned PalBanks = 4;
	localparam int unsigned Pixels   = 8;

	localparam logic [7:0] Alpha     = 8'hff;
	localparam logic [2:0] BgPalRow  = 3'd4;
	localparam logic [2:0] SprPalRow = 3'd0;

	typedef enum logic {
		CMD_TILE_BYTE = 1'b0,
		CMD_PAL_WRITE = 1'b1
	} cmd_t;

	typedef logic [5:0]  pal_entry_t;
	typedef logic [31:0] argb_t;

	typedef struct packed {
		logic       en;
		logic [4:0] addr;
		pal_entry_t data;
	} pal_wr_t;

	localparam logic [23:0] RgbRom [64] = '{
		24'h7c7c7c, 24'h0000fc, 24'h0000bc, 24'h4428bc,
		24'h940084, 24'ha80020, 24'ha81000, 24'h881400,
		24'h503000, 24'h007800, 24'h006800, 24'h005800,
		24'h004058, 24'h000000, 24'h000000, 24'h000000,
		24'hbcbcbc, 24'h0078f8, 24'h0058f8, 24'h6844fc,
		24'hd800cc, 24'he40058, 24'hf83800, 24'he45c10,
		24'hac7c00, 24'h00b800, 24'h00a800, 24'h00a844,
		24'h008888, 24'h000000, 24'h000000, 24'h000000,
		24'hf8f8f8, 24'h3cbcfc, 24'h6888fc, 24'h9878f8,
		24'hf878f8, 24'hf85898, 24'hf87858, 24'hfca044,
		24'hf8b800, 24'hb8f818, 24'h58d854, 24'h58f898,
		24'h00e8d8, 24'h787878, 24'h000000, 24'h000000,
		24'hfcfcfc, 24'ha4e4fc, 24'hb8b8f8, 24'hd8b8f8,
		24'hf8b8f8, 24'hf8a4c0, 24'hf0d0b0, 24'hfce0a8,
		24'hf8d878, 24'hd8f878, 24'hb8f8b8, 24'hb8f8d8,
		24'h00fcfc, 24'hf8d8f8, 24'h000000, 24'h000000
	};

	function automatic argb_t colour_of(input pal_entry_t idx);
		return {Alpha, RgbRom[idx]};
	endfunction

endpackage

>>> hw/rtl/ptar_in_if.sv
// Input channel of the tile row decoder: one tile byte or palette write per beat.
// Depends on nothing.
interface ptar_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [8:0] tile_number;
	logic [3:0] byte_index;
	logic [7:0] tile_byte;
	logic [4:0] palette_address;
	logic [5:0] palette_value;

	modport source (
		output valid, command, tile_number, byte_index, tile_byte,
		       palette_address, palette_value,
		input  ready
	);
	modport sink (
		input  valid, command, tile_number, byte_index, tile_byte,
		       palette_address, palette_value,
		output ready
	);
endinterface

>>> hw/rtl/ptar_out_if.sv
// Output channel of the tile row decoder: one ARGB pixel row per beat.
// Depends on nothing.
interface ptar_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] pixel_index;
	logic [31:0] color_0;
	logic [31:0] color_1;
	logic [31:0] color_2;
	logic [31:0] color_3;
	logic [31:0] color_4;
	logic [31:0] color_5;
	logic [31:0] color_6;
	logic [31:0] color_7;

	modport source (
		output valid, pixel_index, color_0, color_1, color_2, color_3,
		       color_4, color_5, color_6, color_7,
		input  ready
	);
	modport sink (
		input  valid, pixel_index, color_0, color_1, color_2, color_3,
		       color_4, color_5, color_6, color_7,
		output ready
	);
endinterface

>>> hw/rtl/ptar_pal_ram.sv
// Palette RAM: four banks of eight 6-bit entries, one row of four read per cycle.
// Per-entry valid bits give the all-zero reset. Depends on ptar_pkg.
module ptar_pal_ram (
	input  logic                clk,
	input  logic                arst_n,
	input  ptar_pkg::pal_wr_t   wr,
	input  logic                rd_en,
	input  logic [2:0]          rd_row,
	output ptar_pkg::pal_entry_t rd_data [4]
);
	import ptar_pkg::*;

	pal_entry_t mem_q [PalBanks][PalRows];
	logic [31:0] vld_q;
	pal_entry_t  rd_q [PalBanks];
	logic [PalBanks-1:0] rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= '0;
		end else if (rd_en) begin
			for (int b = 0; b < PalBanks; b++) begin
				rd_vld_q[b] <= vld_q[{rd_row, 2'(b)}];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < PalBanks; b++) begin
			if (wr.en && wr.addr[1:0] == 2'(b)) begin
				mem_q[b][wr.addr[4:2]] <= wr.data;
			end
			if (rd_en) begin
				rd_q[b] <= mem_q[b][rd_row];
			end
		end
	end

	always_comb begin
		for (int b = 0; b < PalBanks; b++) begin
			rd_data[b] = rd_vld_q[b] ? rd_q[b] : '0;
		end
	end
endmodule

>>> hw/rtl/ptar_row_dec.sv
// Row decoder: combines both bit planes, picks palette entries, maps to ARGB.
// Pure logic between the input stage and the result register. Depends on ptar_pkg.
module ptar_row_dec (
	input  logic [7:0]           lo_plane,
	input  logic [7:0]           hi_plane,
	input  ptar_pkg::pal_entry_t pal [4],
	output ptar_pkg::argb_t      colour [8]
);
	import ptar_pkg::*;

	always_comb begin
		for (int c = 0; c < Pixels; c++) begin
			colour[c] = colour_of(pal[{hi_plane[7-c], lo_plane[7-c]}]);
		end
	end
endmodule

>>> hw/rtl/planar_tile_to_argb_rows_top.sv
// Top level of the planar tile row decoder: input stage, low-plane store, result register.
// Depends on ptar_pkg, ptar_in_if, ptar_out_if, ptar_pal_ram and ptar_row_dec.
//
//   channel  modport  beat
//   in_ch    sink     tile pattern byte or palette write
//   out_ch   source   pixel index and eight ARGB colours
//
// One beat accepted per cycle unless out_ch stalls with the input stage full.
// A high-plane byte passes registered palette/low-plane reads, then the result register.
// Reset clears the palette to zero at once; no clearing pass.
// A stalled result holds in the output register; an empty input stage still takes a beat.
module planar_tile_to_argb_rows_top #(
	parameter int unsigned TILE_COUNT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	ptar_in_if.sink     in_ch,
	ptar_out_if.source  out_ch
);
	import ptar_pkg::*;

	localparam logic [9:0] TileLimit = 10'(TILE_COUNT);

	logic        in_acc;
	logic        tile_ok;
	logic        lo_wr;
	logic        hi_acc;
	logic        adv;
	pal_wr_t     pal_wr;
	pal_entry_t  pal_rd [4];
	argb_t       colour [8];

	logic [7:0]  low_rows_q [8];
	logic        valid_s1;
	logic [7:0]  hi_s1;
	logic [7:0]  lo_s1;
	logic [14:0] pix_s1;
	logic        out_valid_q;
	logic [14:0] pix_q;
	argb_t       colour_q [8];

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign tile_ok = {1'b0, in_ch.tile_number} < TileLimit;
	assign lo_wr   = in_acc && cmd_t'(in_ch.command) == CMD_TILE_BYTE && tile_ok
		&& !in_ch.byte_index[3];
	assign hi_acc  = in_acc && cmd_t'(in_ch.command) == CMD_TILE_BYTE && tile_ok
		&& in_ch.byte_index[3];
	assign adv     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || !out_valid_q || out_ch.ready;

	assign pal_wr.en   = in_acc && cmd_t'(in_ch.command) == CMD_PAL_WRITE;
	assign pal_wr.addr = in_ch.palette_address;
	assign pal_wr.data = in_ch.palette_value;

	ptar_pal_ram u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd_en   (hi_acc),
		.rd_row  (in_ch.tile_number[8] ? SprPalRow : BgPalRow),
		.rd_data (pal_rd)
	);

	ptar_row_dec u_dec (
		.lo_plane (lo_s1),
		.hi_plane (hi_s1),
		.pal      (pal_rd),
		.colour   (colour)
	);

	// low plane per row, tile number not kept
	always_ff @(posedge clk) begin
		if (lo_wr) begin
			low_rows_q[in_ch.byte_index[2:0]] <= in_ch.tile_byte;
		end
		if (hi_acc) begin
			lo_s1  <= low_rows_q[in_ch.byte_index[2:0]];
			hi_s1  <= in_ch.tile_byte;
			pix_s1 <= {in_ch.tile_number[8:4], in_ch.byte_index[2:0],
				in_ch.tile_number[3:0], 3'b000};
		end
		if (adv) begin
			pix_q    <= pix_s1;
			colour_q <= colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (hi_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.pixel_index = pix_q;
	assign out_ch.color_0     = colour_q[0];
	assign out_ch.color_1     = colour_q[1];
	assign out_ch.color_2     = colour_q[2];
	assign out_ch.color_3     = colour_q[3];
	assign out_ch.color_4     = colour_q[4];
	assign out_ch.color_5     = colour_q[5];
	assign out_ch.color_6     = colour_q[6];
	assign out_ch.color_7     = colour_q[7];

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("input stage did not move into an empty result register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input not ready with empty stage");

	a_pal_no_row: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.command |=> !valid_s1)
		else $error("palette write produced a row");

	a_hi_loads: assert property (@(posedge clk) disable iff (!arst_n)
		hi_acc |=> valid_s1 && pix_s1[6:3] == $past(in_ch.tile_number[3:0]))
		else $error("high-plane beat not loaded into stage");
endmodule
